/* rtl/pre_pkg.sv */
package pre_pkg;

	// Configuration register indexes.
	localparam int CFG_ADDR_W = 3;
	typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

	localparam cfg_addr_t CFG_MATCH_VALUE = 3'd0;
	localparam cfg_addr_t CFG_COL_FIRST   = 3'd1;
	localparam cfg_addr_t CFG_COL_LAST    = 3'd2;
	localparam cfg_addr_t CFG_ROW_FIRST   = 3'd3;
	localparam cfg_addr_t CFG_ROW_LAST    = 3'd4;

	// Classification of one pixel, handed from the front end to the back end.
	typedef struct packed {
		logic empty;     // window is empty, pixel is dropped and the run is closed
		logic match;     // pixel equals the match value
		logic last_col;  // pixel is the last one of its row
	} pixel_flags_t;

	localparam int FLAGS_W = $bits(pixel_flags_t);

endpackage

/* rtl/pixel_run_extraction_top.sv */
// Row run extractor: pixels of a raster window come in on the s_ stream, one
// per transaction, and each horizontal run of pixels equal to match_value
// leaves on the m_ stream as a span (row, first column, last column) once the
// pixel that closes it has been seen. Row and column are counted internally
// from the window corners in the configuration registers and wrap at the end
// of the window; an empty window drops every pixel and closes any open run.
// The block takes one pixel per clock while the queue has room; the front-end
// position counters step as each pixel is taken. The back end retires one
// queued pixel per clock while its output register is free and registers a
// span when it takes the pixel that closes it. A two-entry queue between the
// classifier and the run tracker keeps input flowing, until it fills, while
// the output stalls. Write the configuration only while no span is pending.
module pixel_run_extraction_top #(
	parameter int PIXEL_BITS = 16,
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  pre_pkg::cfg_addr_t    cfg_addr,
	input  logic [((PIXEL_BITS > COORD_BITS) ? PIXEL_BITS : COORD_BITS)-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// pixel
	input  logic [((PIXEL_BITS + 7) / 8) * 8-1:0] s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// span_row, span_col_start, span_col_end
	output logic [((3 * COORD_BITS + 7) / 8) * 8-1:0] m_tdata
);
	import pre_pkg::*;

	localparam int ENTRY_W = 2 * COORD_BITS + FLAGS_W;
	localparam int OUT_W   = ((3 * COORD_BITS + 7) / 8) * 8;

	logic [ENTRY_W-1:0]    front_entry;
	logic                  queue_valid;
	logic                  queue_ready;
	logic [ENTRY_W-1:0]    queue_entry;
	logic [COORD_BITS-1:0] span_row;
	logic [COORD_BITS-1:0] span_col_start;
	logic [COORD_BITS-1:0] span_col_end;

	// Classifier and position counters.
	pre_front #(
		.PIXEL_BITS(PIXEL_BITS),
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.pix_valid(s_tvalid),
		.pix_ready(s_tready),
		.pixel    (s_tdata[PIXEL_BITS-1:0]),
		.entry    (front_entry)
	);

	// Queue between classifier and run tracker.
	pre_fifo #(
		.WIDTH(ENTRY_W),
		.DEPTH(2)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_data  (front_entry),
		.out_valid(queue_valid),
		.out_ready(queue_ready),
		.out_data (queue_entry)
	);

	// Run tracker and output register.
	pre_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.entry_valid   (queue_valid),
		.entry_ready   (queue_ready),
		.entry         (queue_entry),
		.span_valid    (m_tvalid),
		.span_ready    (m_tready),
		.span_row      (span_row),
		.span_col_start(span_col_start),
		.span_col_end  (span_col_end)
	);

	assign m_tdata = OUT_W'({span_col_end, span_col_start, span_row});

endmodule

/* rtl/pre_fifo.sv */
module pre_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push;
	logic             pop;

	assign in_ready  = (count_q != CW'(DEPTH));
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// Storage entries.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/pre_front.sv */
module pre_front #(
	parameter int PIXEL_BITS = 16,
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  pre_pkg::cfg_addr_t    cfg_addr,
	input  logic [((PIXEL_BITS > COORD_BITS) ? PIXEL_BITS : COORD_BITS)-1:0] cfg_wdata,
	input  logic                  pix_valid,
	input  logic                  pix_ready,
	input  logic [PIXEL_BITS-1:0] pixel,
	output logic [2*COORD_BITS+pre_pkg::FLAGS_W-1:0] entry
);
	import pre_pkg::*;

	logic [PIXEL_BITS-1:0] match_value_q;
	logic [COORD_BITS-1:0] col_first_q;
	logic [COORD_BITS-1:0] col_last_q;
	logic [COORD_BITS-1:0] row_first_q;
	logic [COORD_BITS-1:0] row_last_q;
	logic [COORD_BITS-1:0] col_offset_q;
	logic [COORD_BITS-1:0] row_offset_q;

	logic [COORD_BITS-1:0] col_span;
	logic [COORD_BITS-1:0] row_span;
	logic [COORD_BITS-1:0] col;
	logic [COORD_BITS-1:0] row;
	logic                  last_row;
	logic                  accept;
	pixel_flags_t          flags;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_value_q <= '0;
			col_first_q   <= '0;
			col_last_q    <= COORD_BITS'(1023);
			row_first_q   <= '0;
			row_last_q    <= COORD_BITS'(1023);
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_MATCH_VALUE: match_value_q <= cfg_wdata[PIXEL_BITS-1:0];
				CFG_COL_FIRST:   col_first_q   <= cfg_wdata[COORD_BITS-1:0];
				CFG_COL_LAST:    col_last_q    <= cfg_wdata[COORD_BITS-1:0];
				CFG_ROW_FIRST:   row_first_q   <= cfg_wdata[COORD_BITS-1:0];
				CFG_ROW_LAST:    row_last_q    <= cfg_wdata[COORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Classify the incoming pixel against the window and the match value.
	always_comb begin
		flags.empty    = ($signed(col_first_q) > $signed(col_last_q)) ||
		                 ($signed(row_first_q) > $signed(row_last_q));
		col_span       = col_last_q - col_first_q;
		row_span       = row_last_q - row_first_q;
		flags.last_col = (col_offset_q >= col_span);
		flags.match    = (pixel == match_value_q);
		last_row       = (row_offset_q >= row_span);
		col            = col_first_q + col_offset_q;
		row            = row_first_q + row_offset_q;
	end

	assign entry  = {row, col, flags};
	assign accept = pix_valid && pix_ready;

	// Raster position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_offset_q <= '0;
			row_offset_q <= '0;
		end else if (accept) begin
			if (flags.empty) begin
				col_offset_q <= '0;
				row_offset_q <= '0;
			end else if (flags.last_col) begin
				col_offset_q <= '0;
				row_offset_q <= last_row ? '0 : row_offset_q + 1'b1;
			end else begin
				col_offset_q <= col_offset_q + 1'b1;
			end
		end
	end

endmodule

/* rtl/pre_back.sv */
module pre_back #(
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  entry_valid,
	output logic                  entry_ready,
	input  logic [2*COORD_BITS+pre_pkg::FLAGS_W-1:0] entry,
	output logic                  span_valid,
	input  logic                  span_ready,
	output logic [COORD_BITS-1:0] span_row,
	output logic [COORD_BITS-1:0] span_col_start,
	output logic [COORD_BITS-1:0] span_col_end
);
	import pre_pkg::*;

	pixel_flags_t          flags;
	logic [COORD_BITS-1:0] col;
	logic [COORD_BITS-1:0] row;
	logic                  take;
	logic                  emit;
	logic                  in_run_q;
	logic [COORD_BITS-1:0] run_start_q;
	logic                  span_valid_q;
	logic [COORD_BITS-1:0] span_row_q;
	logic [COORD_BITS-1:0] span_col_start_q;
	logic [COORD_BITS-1:0] span_col_end_q;

	assign {row, col, flags} = entry;

	// The output register frees up when it is empty or its transaction completes.
	assign entry_ready = !span_valid_q || span_ready;
	assign take        = entry_valid && entry_ready;
	assign emit        = !flags.empty &&
	                     ((flags.match && flags.last_col) || (!flags.match && in_run_q));

	// Open run tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_run_q <= 1'b0;
		end else if (take) begin
			in_run_q <= !flags.empty && flags.match && !flags.last_col;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !flags.empty && flags.match && !in_run_q) begin
			run_start_q <= col;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_valid_q <= 1'b0;
		end else if (take) begin
			span_valid_q <= emit;
		end else if (span_ready) begin
			span_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			span_row_q       <= row;
			span_col_start_q <= in_run_q ? run_start_q : col;
			span_col_end_q   <= flags.match ? col : col - 1'b1;
		end
	end

	assign span_valid     = span_valid_q;
	assign span_row       = span_row_q;
	assign span_col_start = span_col_start_q;
	assign span_col_end   = span_col_end_q;

endmodule

/* rtl/pre_checker.sv */
module pre_checker #(
	parameter int PIXEL_BITS = 16,
	parameter int COORD_BITS = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_we,
	input pre_pkg::cfg_addr_t    cfg_addr,
	input logic [((PIXEL_BITS > COORD_BITS) ? PIXEL_BITS : COORD_BITS)-1:0] cfg_wdata,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [((PIXEL_BITS + 7) / 8) * 8-1:0] s_tdata,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [((3 * COORD_BITS + 7) / 8) * 8-1:0] m_tdata
);

	// A stalled span holds until its transaction completes.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("span changed while stalled");

	// No span is presented right after reset.
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !m_tvalid)
		else $error("span present after reset");

	// The queue fills only through an accepted pixel.
	a_fill_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid && s_tready))
		else $error("input stalled without a pixel taken");

	// The queue drains only when the output register can take an item.
	a_drain_on_room: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_tready) |-> $past(!m_tvalid || m_tready))
		else $error("queue drained while output was blocked");

endmodule

bind pixel_run_extraction_top pre_checker #(
	.PIXEL_BITS(PIXEL_BITS),
	.COORD_BITS(COORD_BITS)
) u_pre_checker (.*);
